/* hw/rtl/pdbl_pkg.sv */
// Shared types, widths and codes of the pulse-dimming backlight controller.
`default_nettype none
package pdbl_pkg;

    // Field widths
    localparam int OP_W     = 3;
    localparam int LEVEL_W  = 6;
    localparam int ACTION_W = 2;
    localparam int TIME_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Level constants
    localparam logic [LEVEL_W-1:0] MAX_LEVEL      = 6'd32;
    localparam logic [LEVEL_W-1:0] MID_LEVEL      = 6'd16;
    localparam logic [LEVEL_W-1:0] FADE_WAKE_DOWN = 6'd15;

    // Result count cap per command
    localparam int RESULT_LIMIT = 64;
    localparam int CNT_W        = $clog2(RESULT_LIMIT);

    // Default depth of the command queue
    localparam int QUEUE_DEPTH = 4;

    // Command codes
    localparam logic [OP_W-1:0] OP_INIT   = 3'd0;
    localparam logic [OP_W-1:0] OP_DEINIT = 3'd1;
    localparam logic [OP_W-1:0] OP_SET    = 3'd2;
    localparam logic [OP_W-1:0] OP_FADE   = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK   = 3'd4;

    // Init action codes
    localparam logic [ACTION_W-1:0] ACT_OFF   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RESET = 2'd1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_PULSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_GAP      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_GAP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_HIGH  = 2'd3;

    // Register reset values
    localparam logic [TIME_W-1:0] START_PULSE_RST = 16'd110;
    localparam logic [TIME_W-1:0] UP_GAP_RST      = 16'd30;
    localparam logic [TIME_W-1:0] DOWN_GAP_RST    = 16'd200;
    localparam logic [TIME_W-1:0] SHORT_HIGH_RST  = 16'd2;

    // Closing segment of a run
    localparam logic [1:0] TAIL_NONE = 2'd0;
    localparam logic [1:0] TAIL_HIGH = 2'd1;
    localparam logic [1:0] TAIL_LOW  = 2'd2;

    // Timing registers
    typedef struct packed {
        logic [TIME_W-1:0] start_pulse;
        logic [TIME_W-1:0] up_gap;
        logic [TIME_W-1:0] down_gap;
        logic [TIME_W-1:0] short_high;
    } cfg_t;

    // One classified command: the run shape plus its status fields
    typedef struct packed {
        logic               start;
        logic [LEVEL_W-1:0] pairs;
        logic               gap_dn;
        logic [1:0]         tail;
        logic [LEVEL_W-1:0] level_now;
        logic [LEVEL_W-1:0] set_return;
        logic               fade_busy;
    } job_t;

    // One result word
    typedef struct packed {
        logic               has_segment;
        logic               pin_level;
        logic [TIME_W-1:0]  duration_us;
        logic               last;
        logic [LEVEL_W-1:0] level_now;
        logic [LEVEL_W-1:0] set_return;
        logic               fade_busy;
    } res_t;

endpackage
`default_nettype wire

/* hw/rtl/pdbl_ifs.sv */
// Channel interfaces: command, result and register write.
`default_nettype none
interface pdbl_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [pdbl_pkg::OP_W-1:0]      op;
    logic [pdbl_pkg::LEVEL_W-1:0]   target_level;
    logic [pdbl_pkg::ACTION_W-1:0]  init_action;
    logic [pdbl_pkg::TIME_W-1:0]    fade_period_ms;
    modport source (output valid, op, target_level, init_action, fade_period_ms,
                    input ready);
    modport sink (input valid, op, target_level, init_action, fade_period_ms,
                  output ready);
endinterface

interface pdbl_res_if;
    logic                         valid;
    logic                         ready;
    logic                         has_segment;
    logic                         pin_level;
    logic [pdbl_pkg::TIME_W-1:0]  duration_us;
    logic                         last;
    logic [pdbl_pkg::LEVEL_W-1:0] level_now;
    logic [pdbl_pkg::LEVEL_W-1:0] set_return;
    logic                         fade_busy;
    modport source (output valid, has_segment, pin_level, duration_us, last,
                    level_now, set_return, fade_busy, input ready);
    modport sink (input valid, has_segment, pin_level, duration_us, last,
                  level_now, set_return, fade_busy, output ready);
endinterface

interface pdbl_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pdbl_pkg::CFG_IDX_W-1:0] index;
    logic [pdbl_pkg::TIME_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/pdbl_front.sv */
// Command front end: holds dimming state and classifies each command into a run.
`default_nettype none
module pdbl_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    pdbl_cmd_if.sink            cmd,
    input  wire logic           q_full,
    output logic                q_push,
    output pdbl_pkg::job_t      q_data
);
    import pdbl_pkg::*;

    logic               ready_reg, ready_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               fading_reg, fading_next;
    logic [LEVEL_W-1:0] goal_reg, goal_next;
    logic [TIME_W-1:0]  period_reg, period_next;
    logic [TIME_W-1:0]  count_reg, count_next;

    logic [LEVEL_W-1:0] clipped;
    logic [LEVEL_W-1:0] base;
    logic [LEVEL_W-1:0] step_lvl;
    logic               accept;
    job_t               job;

    assign cmd.ready = !q_full;
    assign accept    = cmd.valid && !q_full;
    assign q_push    = accept;
    assign q_data    = job;

    assign clipped = (cmd.target_level > MAX_LEVEL) ? MAX_LEVEL : cmd.target_level;
    // Level the driver sits at before step pulses of a set command
    assign base    = (level_reg == '0 && clipped != '0) ? MID_LEVEL : level_reg;

    // Work out next state and the run shape
    always_comb
    begin
        ready_next  = ready_reg;
        level_next  = level_reg;
        fading_next = fading_reg;
        goal_next   = goal_reg;
        period_next = period_reg;
        count_next  = count_reg;
        step_lvl    = level_reg;
        job         = '0;
        job.tail    = TAIL_NONE;
        case (cmd.op)
            OP_INIT:
            begin
                if (!ready_reg)
                begin
                    level_next  = '0;
                    fading_next = 1'b0;
                    goal_next   = '0;
                    period_next = '0;
                    count_next  = '0;
                    ready_next  = 1'b1;
                    if (cmd.init_action == ACT_OFF)
                    begin
                        job.tail = TAIL_LOW;
                    end
                    else if (cmd.init_action == ACT_RESET)
                    begin
                        job.start  = 1'b1;
                        job.tail   = TAIL_HIGH;
                        level_next = MID_LEVEL;
                    end
                end
            end
            OP_DEINIT:
            begin
                ready_next = 1'b0;
            end
            OP_SET:
            begin
                if (ready_reg && level_reg != cmd.target_level)
                begin
                    job.start = (level_reg == '0 && clipped != '0);
                    if (clipped == '0)
                    begin
                        job.tail = TAIL_LOW;
                    end
                    else if (clipped > base)
                    begin
                        job.pairs = clipped - base;
                        job.tail  = TAIL_HIGH;
                    end
                    else if (clipped < base)
                    begin
                        job.pairs  = base - clipped;
                        job.gap_dn = 1'b1;
                        job.tail   = TAIL_HIGH;
                    end
                    else if (job.start)
                    begin
                        job.tail = TAIL_HIGH;
                    end
                    level_next     = clipped;
                    job.set_return = clipped;
                end
            end
            OP_FADE:
            begin
                if (ready_reg)
                begin
                    fading_next = 1'b1;
                    goal_next   = clipped;
                    period_next = (cmd.fade_period_ms == '0) ? 16'd1 : cmd.fade_period_ms;
                    count_next  = period_next;
                end
            end
            OP_TICK:
            begin
                if (fading_reg)
                begin
                    if (count_reg > 16'd1)
                    begin
                        count_next = count_reg - 16'd1;
                    end
                    else
                    begin
                        count_next = '0;
                        // One fade step toward the goal
                        if (level_reg == '0 && goal_reg != '0)
                        begin
                            job.start  = 1'b1;
                            job.pairs  = FADE_WAKE_DOWN;
                            job.gap_dn = 1'b1;
                            job.tail   = TAIL_HIGH;
                            step_lvl   = 6'd1;
                        end
                        else if (goal_reg == '0 && level_reg == 6'd1)
                        begin
                            job.tail = TAIL_LOW;
                            step_lvl = '0;
                        end
                        else if (level_reg < goal_reg)
                        begin
                            job.pairs = 6'd1;
                            job.tail  = TAIL_HIGH;
                            step_lvl  = level_reg + 6'd1;
                        end
                        else if (level_reg > goal_reg)
                        begin
                            job.pairs  = 6'd1;
                            job.gap_dn = 1'b1;
                            job.tail   = TAIL_HIGH;
                            step_lvl   = level_reg - 6'd1;
                        end
                        level_next = step_lvl;
                        if (step_lvl == goal_reg)
                        begin
                            fading_next = 1'b0;
                        end
                        else
                        begin
                            count_next = period_reg;
                        end
                    end
                end
            end
            default:
            begin
                job.tail = TAIL_NONE;
            end
        endcase
        job.level_now = level_next;
        job.fade_busy = fading_next;
    end

    // Update state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg  <= 1'b0;
            level_reg  <= '0;
            fading_reg <= 1'b0;
            goal_reg   <= '0;
            period_reg <= '0;
            count_reg  <= '0;
        end
        else if (accept)
        begin
            ready_reg  <= ready_next;
            level_reg  <= level_next;
            fading_reg <= fading_next;
            goal_reg   <= goal_next;
            period_reg <= period_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/pdbl_queue.sv */
// Small FIFO of classified commands between front end and segment generator.
`default_nettype none
module pdbl_queue #(
    parameter int DEPTH = pdbl_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire pdbl_pkg::job_t wdata,
    input  wire logic           pop,
    output pdbl_pkg::job_t      rdata,
    output logic                full,
    output logic                not_empty
);
    import pdbl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W_Q-1:0] FULL_CNT = CNT_W_Q'(DEPTH);

    job_t               mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W_Q-1:0] cnt_reg;
    logic               do_push;
    logic               do_pop;

    assign full      = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rdata     = mem[rd_ptr_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/pdbl_back.sv */
// Segment generator: plays out one classified command as a run of result words.
`default_nettype none
module pdbl_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire pdbl_pkg::cfg_t cfg_regs,
    input  wire pdbl_pkg::job_t q_data,
    input  wire logic           q_not_empty,
    output logic                q_pop,
    pdbl_res_if.source          res
);
    import pdbl_pkg::*;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_START  = 3'd1;
    localparam logic [2:0] PH_HI     = 3'd2;
    localparam logic [2:0] PH_LO     = 3'd3;
    localparam logic [2:0] PH_TAIL   = 3'd4;
    localparam logic [2:0] PH_STATUS = 3'd5;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RESULT_LIMIT - 1);

    logic [2:0]         phase_reg;
    logic [2:0]         phase_next;
    job_t               job_reg;
    logic [LEVEL_W-1:0] pairs_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               out_valid_reg;
    res_t               out_reg;
    res_t               seg;
    logic               slot_free;
    logic               emit;
    logic [2:0]         first_phase;

    // Phase that follows the start pulse, or the first one when there is none
    function automatic logic [2:0] after_start(input job_t j);
        logic [2:0] p;
        if (j.pairs != '0)
        begin
            p = PH_HI;
        end
        else if (j.tail != TAIL_NONE)
        begin
            p = PH_TAIL;
        end
        else
        begin
            p = PH_IDLE;
        end
        return p;
    endfunction

    assign first_phase = q_data.start ? PH_START :
                         ((after_start(q_data) == PH_IDLE) ? PH_STATUS : after_start(q_data));

    assign slot_free = !out_valid_reg || res.ready;
    assign emit      = (phase_reg != PH_IDLE) && slot_free;
    assign q_pop     = (phase_reg == PH_IDLE) && q_not_empty;

    // Build the current word and the phase after it
    always_comb
    begin
        seg             = '0;
        seg.has_segment = 1'b1;
        seg.level_now   = job_reg.level_now;
        seg.set_return  = job_reg.set_return;
        seg.fade_busy   = job_reg.fade_busy;
        phase_next      = PH_IDLE;
        case (phase_reg)
            PH_START:
            begin
                seg.pin_level   = 1'b1;
                seg.duration_us = cfg_regs.start_pulse;
                phase_next      = after_start(job_reg);
            end
            PH_HI:
            begin
                seg.pin_level   = 1'b1;
                seg.duration_us = cfg_regs.short_high;
                phase_next      = PH_LO;
            end
            PH_LO:
            begin
                seg.pin_level   = 1'b0;
                seg.duration_us = job_reg.gap_dn ? cfg_regs.down_gap : cfg_regs.up_gap;
                if (pairs_reg > 6'd1)
                begin
                    phase_next = PH_HI;
                end
                else if (job_reg.tail != TAIL_NONE)
                begin
                    phase_next = PH_TAIL;
                end
            end
            PH_TAIL:
            begin
                seg.pin_level = (job_reg.tail == TAIL_HIGH);
            end
            PH_STATUS:
            begin
                seg.has_segment = 1'b0;
            end
            default:
            begin
                seg.has_segment = 1'b0;
            end
        endcase
        // Cut the run at the result cap
        if (cnt_reg == CNT_LAST)
        begin
            phase_next = PH_IDLE;
        end
        seg.last = (phase_next == PH_IDLE);
    end

    // Sequence the run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pairs_reg <= '0;
            cnt_reg   <= '0;
        end
        else if (q_pop)
        begin
            phase_reg <= first_phase;
            pairs_reg <= q_data.pairs;
            cnt_reg   <= '0;
        end
        else if (emit)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_reg + 1'b1;
            if (phase_reg == PH_LO)
            begin
                pairs_reg <= pairs_reg - 6'd1;
            end
        end
    end

    // Hold the command being played out
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_data;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= seg;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.has_segment = out_reg.has_segment;
    assign res.pin_level   = out_reg.pin_level;
    assign res.duration_us = out_reg.duration_us;
    assign res.last        = out_reg.last;
    assign res.level_now   = out_reg.level_now;
    assign res.set_return  = out_reg.set_return;
    assign res.fade_busy   = out_reg.fade_busy;

endmodule
`default_nettype wire

/* hw/rtl/pulse_dimming_backlight_ctrl.sv */
// Top level of the pulse-dimming backlight controller.
//
//   channel | dir | word
//   --------+-----+-------------------------------------------------------------
//   cmd     | in  | op, target_level, init_action, fade_period_ms
//   res     | out | has_segment, pin_level, duration_us, last, level_now,
//           |     | set_return, fade_busy
//   cfg     | in  | index (0..3), data: start_pulse_us, up_gap_us, down_gap_us,
//           |     | short_high_us
//
// A command is taken and queued (QUEUE_DEPTH entries); cmd.ready
// drops only when the queue is full. The segment generator loads a command
// and then plays out its result words, taking no new command until the
// last word is emitted; a run holds at most 64 words (a set across the whole
// range gives 63 words). A stalled res channel holds the output register and
// the generator. Reset clears all state, empties the queue and loads the
// timing registers with their defaults.
`default_nettype none
module pulse_dimming_backlight_ctrl #(
    parameter int QUEUE_DEPTH = pdbl_pkg::QUEUE_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pdbl_cmd_if.sink  cmd,
    pdbl_res_if.source res,
    pdbl_cfg_if.sink  cfg
);
    import pdbl_pkg::*;

    cfg_t cfg_reg;
    job_t push_data;
    job_t pop_data;
    logic push;
    logic pop;
    logic q_full;
    logic q_not_empty;

    assign cfg.ready = 1'b1;

    // Write timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_pulse <= START_PULSE_RST;
            cfg_reg.up_gap      <= UP_GAP_RST;
            cfg_reg.down_gap    <= DOWN_GAP_RST;
            cfg_reg.short_high  <= SHORT_HIGH_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_START_PULSE: cfg_reg.start_pulse <= cfg.data;
                CFG_UP_GAP:      cfg_reg.up_gap      <= cfg.data;
                CFG_DOWN_GAP:    cfg_reg.down_gap    <= cfg.data;
                CFG_SHORT_HIGH:  cfg_reg.short_high  <= cfg.data;
                default:         cfg_reg.start_pulse <= cfg_reg.start_pulse;
            endcase
        end
    end

    pdbl_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .q_full (q_full),
        .q_push (push),
        .q_data (push_data)
    );

    pdbl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata     (push_data),
        .pop       (pop),
        .rdata     (pop_data),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    pdbl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_regs    (cfg_reg),
        .q_data      (pop_data),
        .q_not_empty (q_not_empty),
        .q_pop       (pop),
        .res         (res)
    );

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Testbench for the pulse-dimming backlight controller: directed and random commands.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pdbl_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [ACTION_W-1:0] ACT_KEEP_PINS = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_SPARE     = 2'd3;
    localparam logic [OP_W-1:0]     OP_SPARE5     = 3'd5;
    localparam logic [OP_W-1:0]     OP_SPARE7     = 3'd7;

    localparam int SETTLE_CYCLES = 70;
    localparam int LONG_STALL    = 400;
    localparam int PHASE_ITEMS   = 36;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [LEVEL_W-1:0]  target_level;
        logic [ACTION_W-1:0] init_action;
        logic [TIME_W-1:0]   fade_period_ms;
    } cmd_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Driven copies of the block inputs, known from time zero
    logic                 cmd_valid_q = 1'b0;
    cmd_t                 cmd_word_q  = '0;
    logic                 res_ready_q = 1'b0;
    logic                 cfg_valid_q = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index_q = '0;
    logic [TIME_W-1:0]    cfg_data_q  = '0;

    pdbl_cmd_if cmd_ch();
    pdbl_res_if res_ch();
    pdbl_cfg_if cfg_ch();

    assign cmd_ch.valid          = cmd_valid_q;
    assign cmd_ch.op             = cmd_word_q.op;
    assign cmd_ch.target_level   = cmd_word_q.target_level;
    assign cmd_ch.init_action    = cmd_word_q.init_action;
    assign cmd_ch.fade_period_ms = cmd_word_q.fade_period_ms;
    assign res_ch.ready          = res_ready_q;
    assign cfg_ch.valid          = cfg_valid_q;
    assign cfg_ch.index          = cfg_index_q;
    assign cfg_ch.data           = cfg_data_q;

    pulse_dimming_backlight_ctrl i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    always #1 clk = ~clk;

    // Stimulus and pacing
    cmd_t cmd_pending[$];
    logic cmd_taken      = 1'b0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   stall_req      = 0;
    int   stall_ack      = 0;
    int   stall_left     = 0;
    int   items_queued   = 0;
    int   mismatches     = 0;
    int   words_seen     = 0;

    // Shadow of the controller: timing registers and dimming state
    cfg_t               timing = '{START_PULSE_RST, UP_GAP_RST, DOWN_GAP_RST, SHORT_HIGH_RST};
    logic               powered   = 1'b0;
    logic [LEVEL_W-1:0] lvl       = '0;
    logic               fade_on   = 1'b0;
    logic [LEVEL_W-1:0] goal      = '0;
    logic [TIME_W-1:0]  period_ms = '0;
    logic [TIME_W-1:0]  countdown = '0;
    res_t               run_segs[$];
    res_t               expected_words[$];

    // Append one pin segment, dropping anything past the per-command cap
    function automatic void push_seg(logic pin, logic [TIME_W-1:0] dur);
        res_t w;
        if (run_segs.size() >= RESULT_LIMIT)
        begin
            return;
        end
        w = '0;
        w.has_segment = 1'b1;
        w.pin_level   = pin;
        w.duration_us = dur;
        run_segs.push_back(w);
    endfunction

    // n short pulses each followed by a gap, then hold the line high
    function automatic void push_steps(logic [LEVEL_W-1:0] n, logic [TIME_W-1:0] gap);
        for (int i = 0; i < n; i++)
        begin
            push_seg(1'b1, timing.short_high);
            push_seg(1'b0, gap);
        end
        push_seg(1'b1, '0);
    endfunction

    // Move one level toward the fade goal
    function automatic void fade_advance();
        if (lvl == '0 && goal != '0)
        begin
            push_seg(1'b1, timing.start_pulse);
            push_steps(FADE_WAKE_DOWN, timing.down_gap);
            lvl = 6'd1;
        end
        else if (goal == '0 && lvl == 6'd1)
        begin
            push_seg(1'b0, '0);
            lvl = '0;
        end
        else if (lvl < goal)
        begin
            push_steps(6'd1, timing.up_gap);
            lvl = lvl + 1'b1;
        end
        else if (lvl > goal)
        begin
            push_steps(6'd1, timing.down_gap);
            lvl = lvl - 1'b1;
        end
        if (lvl == goal)
            fade_on = 1'b0;
        else
            countdown = period_ms;
    endfunction

    // Work out the result words of one accepted command
    function automatic void predict_words(cmd_t c);
        logic [LEVEL_W-1:0] clipped;
        logic [LEVEL_W-1:0] answer;
        res_t               w;
        clipped = (c.target_level > MAX_LEVEL) ? MAX_LEVEL : c.target_level;
        answer  = '0;
        run_segs.delete();
        case (c.op)
            OP_INIT:
            begin
                if (!powered)
                begin
                    lvl       = '0;
                    fade_on   = 1'b0;
                    goal      = '0;
                    period_ms = '0;
                    countdown = '0;
                    if (c.init_action == ACT_OFF)
                    begin
                        push_seg(1'b0, '0);
                    end
                    else if (c.init_action == ACT_RESET)
                    begin
                        push_seg(1'b1, timing.start_pulse);
                        push_seg(1'b1, '0);
                        lvl = MID_LEVEL;
                    end
                    powered = 1'b1;
                end
            end
            OP_DEINIT:
            begin
                powered = 1'b0;
            end
            OP_SET:
            begin
                if (powered && lvl != c.target_level)
                begin
                    if (lvl == '0 && clipped != '0)
                    begin
                        push_seg(1'b1, timing.start_pulse);
                        lvl = MID_LEVEL;
                        if (clipped == lvl)
                            push_seg(1'b1, '0);
                    end
                    if (clipped == '0)
                        push_seg(1'b0, '0);
                    else if (clipped > lvl)
                        push_steps(clipped - lvl, timing.up_gap);
                    else if (clipped < lvl)
                        push_steps(lvl - clipped, timing.down_gap);
                    lvl    = clipped;
                    answer = clipped;
                end
            end
            OP_FADE:
            begin
                if (powered)
                begin
                    fade_on   = 1'b1;
                    goal      = clipped;
                    period_ms = (c.fade_period_ms == '0) ? 16'd1 : c.fade_period_ms;
                    countdown = period_ms;
                end
            end
            OP_TICK:
            begin
                if (fade_on)
                begin
                    if (countdown > 16'd1)
                    begin
                        countdown = countdown - 1'b1;
                    end
                    else
                    begin
                        countdown = '0;
                        fade_advance();
                    end
                end
            end
            default: ;
        endcase
        // A command with no segment still answers with one status word
        if (run_segs.size() == 0)
            run_segs.push_back('0);
        foreach (run_segs[k])
        begin
            w            = run_segs[k];
            w.last       = (k == run_segs.size() - 1);
            w.level_now  = lvl;
            w.set_return = answer;
            w.fade_busy  = fade_on;
            expected_words.push_back(w);
        end
    endfunction

    function automatic string word_str(res_t w);
        return $sformatf("seg=%0b pin=%0b dur=%0d last=%0b level=%0d ret=%0d busy=%0b",
                         w.has_segment, w.pin_level, w.duration_us, w.last,
                         w.level_now, w.set_return, w.fade_busy);
    endfunction

    // Note each accepted command and predict its words
    always @(posedge clk)
    begin
        cmd_taken = cmd_valid_q && cmd_ch.ready;
        if (cmd_taken)
            predict_words(cmd_word_q);
    end

    // Hold the command word until taken, then advance or idle
    always @(negedge clk)
    begin
        if (rst_n && (!cmd_valid_q || cmd_taken))
        begin
            if (cmd_pending.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cmd_word_q  <= cmd_pending.pop_front();
                cmd_valid_q <= 1'b1;
            end
            else
            begin
                cmd_valid_q <= 1'b0;
            end
        end
    end

    // Drive result ready: random stalls, or a long hold-off on request
    always @(negedge clk)
    begin
        if (stall_ack != stall_req)
        begin
            stall_ack  = stall_req;
            stall_left = LONG_STALL;
        end
        if (stall_left > 0)
        begin
            stall_left  = stall_left - 1;
            res_ready_q <= 1'b0;
        end
        else
        begin
            res_ready_q <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check each result word against the oldest expectation
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && res_ch.valid && res_ready_q)
        begin
            got.has_segment = res_ch.has_segment;
            got.pin_level   = res_ch.pin_level;
            got.duration_us = res_ch.duration_us;
            got.last        = res_ch.last;
            got.level_now   = res_ch.level_now;
            got.set_return  = res_ch.set_return;
            got.fade_busy   = res_ch.fade_busy;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] unexpected result word: %s", $realtime, word_str(got));
            end
            else
            begin
                want = expected_words.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("[%0t] word %0d mismatch\n  expected %s\n  actual   %s",
                                 $realtime, words_seen, word_str(want), word_str(got));
                end
            end
            words_seen++;
        end
    end

    function automatic cmd_t make_cmd(logic [OP_W-1:0] op, logic [LEVEL_W-1:0] tl,
                                      logic [ACTION_W-1:0] act, logic [TIME_W-1:0] per);
        cmd_t c;
        c.op             = op;
        c.target_level   = tl;
        c.init_action    = act;
        c.fade_period_ms = per;
        return c;
    endfunction

    // Queue a command with a random init action
    function automatic void queue_cmd(logic [OP_W-1:0] op, logic [LEVEL_W-1:0] tl,
                                      logic [TIME_W-1:0] per);
        cmd_pending.push_back(make_cmd(op, tl, ACTION_W'($urandom_range(3)), per));
        items_queued++;
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        else if (r < 25)
            return LEVEL_W'($urandom_range(63, 32));
        else
            return LEVEL_W'($urandom_range(31, 1));
    endfunction

    function automatic logic [TIME_W-1:0] any_time();
        return TIME_W'($urandom_range(65535));
    endfunction

    // Mostly well-formed dimming sequences, with some power cycling and noise
    function automatic void queue_random(int n);
        int               stop_at;
        int               r;
        logic [TIME_W-1:0] per;
        stop_at = items_queued + n;
        while (items_queued < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                queue_cmd(OP_DEINIT, LEVEL_W'($urandom_range(63)), any_time());
                if ($urandom_range(1) == 1)
                    queue_cmd(OP_INIT, LEVEL_W'($urandom_range(63)), any_time());
            end
            else if (r < 16)
            begin
                queue_cmd(OP_INIT, LEVEL_W'($urandom_range(63)), any_time());
            end
            else if (r < 45)
            begin
                queue_cmd(OP_SET, pick_level(), any_time());
            end
            else if (r < 80)
            begin
                // Start from off now and then so the wake-up step is reached
                if ($urandom_range(3) == 0)
                    queue_cmd(OP_SET, '0, any_time());
                per = ($urandom_range(4) == 0) ? any_time() : TIME_W'($urandom_range(3));
                queue_cmd(OP_FADE, pick_level(), per);
                repeat ($urandom_range(40, 4))
                    queue_cmd(OP_TICK, LEVEL_W'($urandom_range(63)), any_time());
            end
            else if (r < 90)
            begin
                repeat ($urandom_range(6, 1))
                    queue_cmd(OP_TICK, LEVEL_W'($urandom_range(63)), any_time());
            end
            else
            begin
                queue_cmd(OP_W'($urandom_range(OP_SPARE7, OP_SPARE5)),
                          LEVEL_W'($urandom_range(63)), any_time());
            end
        end
    endfunction

    // Write all four timing registers and mirror them in the shadow
    task automatic write_timing(logic [TIME_W-1:0] sp, logic [TIME_W-1:0] ug,
                                logic [TIME_W-1:0] dg, logic [TIME_W-1:0] sh);
        logic [CFG_IDX_W-1:0] idx[4];
        logic [TIME_W-1:0]    val[4];
        idx = '{CFG_START_PULSE, CFG_UP_GAP, CFG_DOWN_GAP, CFG_SHORT_HIGH};
        val = '{sp, ug, dg, sh};
        for (int i = 0; i < 4; i++)
        begin
            @(negedge clk);
            cfg_valid_q <= 1'b1;
            cfg_index_q <= idx[i];
            cfg_data_q  <= val[i];
            do
                @(posedge clk);
            while (!cfg_ch.ready);
            case (idx[i])
                CFG_START_PULSE: timing.start_pulse = val[i];
                CFG_UP_GAP:      timing.up_gap      = val[i];
                CFG_DOWN_GAP:    timing.down_gap    = val[i];
                CFG_SHORT_HIGH:  timing.short_high  = val[i];
                default: ;
            endcase
        end
        @(negedge clk);
        cfg_valid_q <= 1'b0;
    endtask

    // Wait until every command is taken and every word is back, then settle
    task automatic drain();
        do
            @(posedge clk);
        while (cmd_pending.size() != 0 || cmd_valid_q || expected_words.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int send_pct[4];
        int recv_pct[4];
        send_pct = '{57, 0, 14, 0};
        recv_pct = '{0, 57, 14, 0};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed pass with reset timing and no idling
        cmd_pending.push_back(make_cmd(OP_FADE, 6'd10, ACT_OFF, 16'hFFFF));
        cmd_pending.push_back(make_cmd(OP_SET, 6'd5, ACT_OFF, '0));
        cmd_pending.push_back(make_cmd(OP_INIT, '0, ACT_KEEP_PINS, '0));
        cmd_pending.push_back(make_cmd(OP_INIT, '0, ACT_RESET, '0));
        cmd_pending.push_back(make_cmd(OP_DEINIT, '0, ACT_OFF, '0));
        cmd_pending.push_back(make_cmd(OP_INIT, '0, ACT_RESET, '0));
        cmd_pending.push_back(make_cmd(OP_DEINIT, '0, ACT_OFF, '0));
        cmd_pending.push_back(make_cmd(OP_INIT, '0, ACT_OFF, '0));
        cmd_pending.push_back(make_cmd(OP_SET, 6'd63, ACT_OFF, '0));
        cmd_pending.push_back(make_cmd(OP_SET, 6'd40, ACT_OFF, '0));
        cmd_pending.push_back(make_cmd(OP_SET, MAX_LEVEL, ACT_OFF, '0));
        cmd_pending.push_back(make_cmd(OP_SET, 6'd1, ACT_OFF, '0));
        cmd_pending.push_back(make_cmd(OP_SET, '0, ACT_OFF, '0));
        cmd_pending.push_back(make_cmd(OP_SET, MID_LEVEL, ACT_OFF, '0));
        cmd_pending.push_back(make_cmd(OP_SET, 6'd2, ACT_OFF, '0));
        cmd_pending.push_back(make_cmd(OP_FADE, '0, ACT_OFF, '0));
        cmd_pending.push_back(make_cmd(OP_TICK, '0, ACT_OFF, '0));
        cmd_pending.push_back(make_cmd(OP_TICK, '0, ACT_OFF, '0));
        cmd_pending.push_back(make_cmd(OP_FADE, 6'd50, ACT_OFF, 16'd2));
        cmd_pending.push_back(make_cmd(OP_TICK, '0, ACT_OFF, '0));
        cmd_pending.push_back(make_cmd(OP_TICK, '0, ACT_OFF, '0));
        cmd_pending.push_back(make_cmd(OP_DEINIT, '0, ACT_OFF, '0));
        cmd_pending.push_back(make_cmd(OP_TICK, '0, ACT_OFF, '0));
        cmd_pending.push_back(make_cmd(OP_TICK, '0, ACT_OFF, '0));
        cmd_pending.push_back(make_cmd(OP_SPARE7, '0, ACT_OFF, '0));
        cmd_pending.push_back(make_cmd(OP_INIT, '0, ACT_SPARE, '0));
        drain();

        // Random phases, each with its own timing and idling mix
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: write_timing('0, '0, '0, '0);
                1: write_timing('1, '1, '1, '1);
                2: write_timing(any_time(), any_time(), any_time(), any_time());
                default: write_timing(START_PULSE_RST, UP_GAP_RST, DOWN_GAP_RST,
                                      SHORT_HIGH_RST);
            endcase
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            if (ph == 3)
            begin
                // Hold off results while long runs keep arriving
                stall_req++;
                queue_cmd(OP_DEINIT, '0, any_time());
                cmd_pending.push_back(make_cmd(OP_INIT, '0, ACT_RESET, any_time()));
                items_queued++;
                for (int i = 0; i < 10; i++)
                    queue_cmd(OP_SET, (i % 2 == 0) ? MAX_LEVEL : 6'd1, any_time());
            end
            queue_random(PHASE_ITEMS);
            drain();
        end

        if (mismatches == 0 && expected_words.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Guard against a hang
    initial
    begin
        #800000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/pdbl_pkg.sv
hw/rtl/pdbl_ifs.sv
hw/rtl/pdbl_front.sv
hw/rtl/pdbl_queue.sv
hw/rtl/pdbl_back.sv
hw/rtl/pulse_dimming_backlight_ctrl.sv
verif/tb_top.sv
